>>> sv/kmd_pkg.sv
// ----------------------------------------------------------------------------
// Knight move distance package
// Word types for the query and answer channels, and the knight move table.
// ----------------------------------------------------------------------------
package kmd_pkg;

	localparam int COUNT_W = 12;
	localparam int MOVE_W  = 3;

	localparam logic [MOVE_W-1:0] FIRST_MOVE = 3'd0;
	localparam logic [MOVE_W-1:0] LAST_MOVE  = 3'd7;

	// row and column step of each knight move
	localparam logic signed [2:0] MOVE_DR [8] = '{
		-3'sd2, -3'sd2, -3'sd1, -3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2
	};
	localparam logic signed [2:0] MOVE_DC [8] = '{
		-3'sd1, 3'sd1, -3'sd2, 3'sd2, -3'sd2, 3'sd2, -3'sd1, 3'sd1
	};

	typedef struct packed {
		logic [6:0] board_rows;
		logic [6:0] board_cols;
		logic [5:0] start_row;
		logic [5:0] start_col;
		logic [5:0] target_row;
		logic [5:0] target_col;
	} query_t;

	typedef struct packed {
		logic               reachable;
		logic [COUNT_W-1:0] move_count;
	} answer_t;

endpackage

>>> sv/kmd_ram.sv
// ----------------------------------------------------------------------------
// Knight move distance RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kmd_ram #(
	parameter int DATA_W = 1,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> sv/kmd_move.sv
// ----------------------------------------------------------------------------
// Knight move distance move unit
// Apply one knight move to a square and check that it stays on the board.
// ----------------------------------------------------------------------------
module kmd_move import kmd_pkg::*; #(
	parameter int SIDE_W = 6
) (
	input  logic [SIDE_W-1:0]   row,
	input  logic [SIDE_W-1:0]   col,
	input  logic [MOVE_W-1:0]   move,
	input  logic [6:0]          board_rows,
	input  logic [6:0]          board_cols,
	output logic [2*SIDE_W-1:0] square,
	output logic                on_board
);

	logic signed [SIDE_W+1:0] nr;
	logic signed [SIDE_W+1:0] nc;

	always_comb begin
		nr = $signed({2'b00, row}) + (SIDE_W+2)'(MOVE_DR[move]);
		nc = $signed({2'b00, col}) + (SIDE_W+2)'(MOVE_DC[move]);
		on_board = !nr[SIDE_W+1] && !nc[SIDE_W+1] &&
			(int'(nr) < int'(board_rows)) && (int'(nc) < int'(board_cols));
		square = {nr[SIDE_W-1:0], nc[SIDE_W-1:0]};
	end

endmodule

>>> sv/knight_move_distance_bfs.sv
// Sequence: clear the visited map over its 2^(2*ceil(log2(MAX_SIDE))) entries (4096 at 64),
//   seed the start square, then pop, load and check each dequeued square, try each
//   move, visit each on-board move, pop once more when the queue runs dry, then load.
// A bad board or an off-board square skips the search: S_DONE loads the answer directly.
// Throughput: one query at a time; the query side stalls until the answer is loaded.
// Reset: arst_n clears the sequencer and answer valid; RAM contents are not reset.
// ----------------------------------------------------------------------------
// Knight move distance search
// Breadth-first search of knight moves from a start square to a target square,
// using a square queue, a distance store and a visited map in RAM.
// ----------------------------------------------------------------------------
module knight_move_distance_bfs import kmd_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_stall,
	input  query_t  query,
	output logic    answer_valid,
	input  logic    answer_stall,
	output answer_t answer
);

	localparam int SIDE_W = $clog2(MAX_SIDE);
	localparam int IDX_W  = 2 * SIDE_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SEED,
		S_POP,
		S_LOAD,
		S_CHECK,
		S_MOVE,
		S_VISIT,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W:0]     head_q;
	logic [IDX_W:0]     tail_q;
	logic [6:0]         rows_q;
	logic [6:0]         cols_q;
	logic [IDX_W-1:0]   start_q;
	logic [IDX_W-1:0]   target_q;
	logic [SIDE_W-1:0]  cur_row_q;
	logic [SIDE_W-1:0]  cur_col_q;
	logic               is_target_q;
	logic [COUNT_W-1:0] dist_q;
	logic [MOVE_W-1:0]  move_q;
	logic [IDX_W-1:0]   nb_q;
	answer_t            res_q;
	answer_t            answer_q;
	logic               answer_valid_q;

	// RAM ports
	logic               vis_wr_en;
	logic [IDX_W-1:0]   vis_wr_addr;
	logic               vis_wr_data;
	logic               vis_rd;
	logic               dist_wr_en;
	logic [IDX_W-1:0]   dist_wr_addr;
	logic [COUNT_W-1:0] dist_wr_data;
	logic [COUNT_W-1:0] dist_rd;
	logic               sq_wr_en;
	logic [IDX_W-1:0]   sq_wr_addr;
	logic [IDX_W-1:0]   sq_wr_data;
	logic [IDX_W-1:0]   sq_rd;

	// move unit
	logic [IDX_W-1:0]   mv_square;
	logic               mv_on_board;

	logic               query_ok;
	logic               new_square;

	assign query_stall  = (state_q != S_IDLE);
	assign answer_valid = answer_valid_q;
	assign answer       = answer_q;

	// Both squares must sit on a board of legal size.
	assign query_ok = (query.board_rows != 7'd0) && (query.board_cols != 7'd0) &&
		(int'(query.board_rows) <= MAX_SIDE) && (int'(query.board_cols) <= MAX_SIDE) &&
		({1'b0, query.start_row} < query.board_rows) &&
		({1'b0, query.start_col} < query.board_cols) &&
		({1'b0, query.target_row} < query.board_rows) &&
		({1'b0, query.target_col} < query.board_cols);

	// A neighbor not yet seen joins the queue one step farther out.
	assign new_square = (state_q == S_VISIT) && !vis_rd;

	kmd_move #(
		.SIDE_W (SIDE_W)
	) u_move (
		.row        (cur_row_q),
		.col        (cur_col_q),
		.move       (move_q),
		.board_rows (rows_q),
		.board_cols (cols_q),
		.square     (mv_square),
		.on_board   (mv_on_board)
	);

	// RAM write steering: clear pass, seed of the start square, new neighbors.
	always_comb begin
		vis_wr_en    = 1'b0;
		vis_wr_addr  = nb_q;
		vis_wr_data  = 1'b1;
		dist_wr_en   = new_square;
		dist_wr_addr = nb_q;
		dist_wr_data = dist_q + COUNT_W'(1);
		sq_wr_en     = new_square;
		sq_wr_addr   = tail_q[IDX_W-1:0];
		sq_wr_data   = nb_q;
		case (state_q)
			S_CLEAR: begin
				vis_wr_en   = 1'b1;
				vis_wr_addr = clr_q;
				vis_wr_data = 1'b0;
			end
			S_SEED: begin
				vis_wr_en    = 1'b1;
				vis_wr_addr  = start_q;
				dist_wr_en   = 1'b1;
				dist_wr_addr = start_q;
				dist_wr_data = '0;
				sq_wr_en     = 1'b1;
				sq_wr_addr   = '0;
				sq_wr_data   = start_q;
			end
			S_VISIT: begin
				vis_wr_en = !vis_rd;
			end
			default: begin
				vis_wr_en = 1'b0;
			end
		endcase
	end

	kmd_ram #(
		.DATA_W (1),
		.ADDR_W (IDX_W)
	) u_visited (
		.clk     (clk),
		.wr_en   (vis_wr_en),
		.wr_addr (vis_wr_addr),
		.wr_data (vis_wr_data),
		.rd_addr (mv_square),
		.rd_data (vis_rd)
	);

	kmd_ram #(
		.DATA_W (COUNT_W),
		.ADDR_W (IDX_W)
	) u_distance (
		.clk     (clk),
		.wr_en   (dist_wr_en),
		.wr_addr (dist_wr_addr),
		.wr_data (dist_wr_data),
		.rd_addr (sq_rd),
		.rd_data (dist_rd)
	);

	kmd_ram #(
		.DATA_W (IDX_W),
		.ADDR_W (IDX_W)
	) u_queue (
		.clk     (clk),
		.wr_en   (sq_wr_en),
		.wr_addr (sq_wr_addr),
		.wr_data (sq_wr_data),
		.rd_addr (head_q[IDX_W-1:0]),
		.rd_data (sq_rd)
	);

	// Sequencer: clear, seed, then pop a square, fetch its distance, stop if it is the
	// target, else try the eight moves in turn through the shared move unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			clr_q          <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			move_q         <= FIRST_MOVE;
			answer_valid_q <= 1'b0;
		end else begin
			// drop the answer once the far side takes it, unless a new one loads now
			if (answer_valid_q && !answer_stall && (state_q != S_DONE)) begin
				answer_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (query_valid) begin
						rows_q   <= query.board_rows;
						cols_q   <= query.board_cols;
						start_q  <= {SIDE_W'(query.start_row), SIDE_W'(query.start_col)};
						target_q <= {SIDE_W'(query.target_row), SIDE_W'(query.target_col)};
						clr_q    <= '0;
						res_q    <= '0;
						state_q  <= query_ok ? S_CLEAR : S_DONE;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == '1) begin
						state_q <= S_SEED;
					end
				end
				S_SEED: begin
					head_q  <= '0;
					tail_q  <= (IDX_W+1)'(1);
					state_q <= S_POP;
				end
				S_POP: begin
					if (head_q == tail_q) begin
						// queue ran dry: target cannot be reached
						res_q   <= '0;
						state_q <= S_DONE;
					end else begin
						head_q  <= head_q + (IDX_W+1)'(1);
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cur_row_q   <= sq_rd[IDX_W-1 -: SIDE_W];
					cur_col_q   <= sq_rd[SIDE_W-1:0];
					is_target_q <= (sq_rd == target_q);
					state_q     <= S_CHECK;
				end
				S_CHECK: begin
					if (is_target_q) begin
						res_q.reachable  <= 1'b1;
						res_q.move_count <= dist_rd;
						state_q          <= S_DONE;
					end else begin
						dist_q  <= dist_rd;
						move_q  <= FIRST_MOVE;
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					nb_q <= mv_square;
					if (mv_on_board) begin
						state_q <= S_VISIT;
					end else if (move_q == LAST_MOVE) begin
						state_q <= S_POP;
					end else begin
						move_q <= move_q + MOVE_W'(1);
					end
				end
				S_VISIT: begin
					if (new_square) begin
						tail_q <= tail_q + (IDX_W+1)'(1);
					end
					if (move_q == LAST_MOVE) begin
						state_q <= S_POP;
					end else begin
						move_q  <= move_q + MOVE_W'(1);
						state_q <= S_MOVE;
					end
				end
				S_DONE: begin
					// hold the result until the answer register is free
					if (!answer_valid_q || !answer_stall) begin
						answer_q       <= res_q;
						answer_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/kmd_checker.sv
// ----------------------------------------------------------------------------
// Knight move distance checker
// Port-level properties of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module kmd_checker import kmd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    query_valid,
	input logic    query_stall,
	input query_t  query,
	input logic    answer_valid,
	input logic    answer_stall,
	input answer_t answer
);

	a_answer_held: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && answer_stall |=> answer_valid)
		else $error("answer word dropped while stalled");

	a_answer_stable: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && answer_stall |=> $stable(answer))
		else $error("answer word changed while stalled");

	a_busy_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && !query_stall |=> query_stall)
		else $error("query side not stalled after a query word");

	a_unreachable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && !answer.reachable |-> (answer.move_count == '0))
		else $error("unreachable answer carries a move count");

	a_query_known: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && !query_stall |-> !$isunknown(query))
		else $error("query word has unknown bits");

endmodule

bind knight_move_distance_bfs kmd_checker u_kmd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.query_valid  (query_valid),
	.query_stall  (query_stall),
	.query        (query),
	.answer_valid (answer_valid),
	.answer_stall (answer_stall),
	.answer       (answer)
);
